FILE: design/dmf_pkg.sv
// ----------------------------------------------------------------------------
// dmf_pkg
// Shared types and constants for the decimating mode filter with history.
// ----------------------------------------------------------------------------
`default_nettype none

package dmf_pkg;

   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_READ   = 1'b1;

   localparam logic [1:0] REG_COLOUR0 = 2'd0;
   localparam logic [1:0] REG_COLOUR1 = 2'd1;
   localparam logic [1:0] REG_COLOUR2 = 2'd2;
   localparam logic [1:0] REG_COLOUR3 = 2'd3;

   localparam logic [31:0] COLOUR0_RESET = 32'hff20_2020;
   localparam logic [31:0] COLOUR1_RESET = 32'hff00_ff00;
   localparam logic [31:0] COLOUR2_RESET = 32'hff00_90e0;
   localparam logic [31:0] COLOUR3_RESET = 32'hff00_00ff;

   localparam logic [2:0] BIN_MAX = 3'd7;
   localparam int         NUM_BINS = 4;

   typedef logic [2:0] bin_type;
   typedef bin_type [NUM_BINS-1:0] bin_set_type;

   // request as it travels through the compute stage
   typedef struct packed {
      logic       func;
      logic [2:0] channel;
      logic [1:0] stage;
      logic       closes;
      logic       ch_ok;
      logic [6:0] age;
   } item_type;

   // outcome of the mode vote
   typedef struct packed {
      logic [1:0] best;
   } vote_type;

   // ring status for the request in the compute stage
   typedef struct packed {
      logic       present;
      logic [6:0] length;
   } ring_status_type;

endpackage

`default_nettype wire

FILE: design/dmf_ram.sv
// ----------------------------------------------------------------------------
// dmf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                                   clock,
   input  wire                                   wr_en,
   input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]                      wr_data,
   input  wire                                   rd_en,
   input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/dmf_bins.sv
// ----------------------------------------------------------------------------
// dmf_bins
// Per-channel stage bins in RAM: count, saturate, vote and clear.
// ----------------------------------------------------------------------------
`default_nettype none

module dmf_bins
   import dmf_pkg::*;
#(
   parameter int NUM_CHANNELS = 8,
   parameter int CH_W         = 3
) (
   input  wire             clock,
   input  wire             reset,
   input  wire             rd_en,
   input  wire  [CH_W-1:0] rd_addr,
   input  wire             proc_en,
   input  wire  item_type  item,
   output vote_type        vote
);

   localparam int BW = NUM_BINS * 3;

   logic              valid_ff [NUM_CHANNELS];
   logic              fwd_hit_ff;
   bin_set_type       fwd_data_ff;
   logic [BW-1:0]     ram_q;
   logic              wr_en;
   logic [CH_W-1:0]   ci;
   bin_set_type       cur;
   bin_set_type       inc;
   bin_set_type       wr_bins;
   logic [1:0]        best;
   bin_type           best_cnt;

   assign ci    = item.ch_ok ? CH_W'(item.channel) : '0;
   assign wr_en = proc_en && (item.func == FUNC_SAMPLE) && item.ch_ok;

   always_comb begin
      if (fwd_hit_ff) begin
         cur = fwd_data_ff;
      end else if (valid_ff[ci]) begin
         cur = bin_set_type'(ram_q);
      end else begin
         cur = '0;
      end
      inc = cur;
      if (cur[item.stage] < BIN_MAX) begin
         inc[item.stage] = cur[item.stage] + 3'd1;
      end
      best     = 2'd0;
      best_cnt = '0;
      for (int j = 0; j < NUM_BINS; j++) begin
         if (inc[j] >= best_cnt) begin
            best     = 2'(j);
            best_cnt = inc[j];
         end
      end
      wr_bins = item.closes ? bin_set_type'('0) : inc;
   end

   assign vote.best = best;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            valid_ff[i] <= 1'b0;
         end
         fwd_hit_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[ci] <= 1'b1;
         end
         if (rd_en) begin
            fwd_hit_ff <= wr_en && (ci == rd_addr);
         end
      end
      if (rd_en) begin
         fwd_data_ff <= wr_bins;
      end
   end

   dmf_ram #(
      .WIDTH (BW),
      .DEPTH (NUM_CHANNELS)
   ) u_bin_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ci),
      .wr_data (BW'(wr_bins)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

endmodule

`default_nettype wire

FILE: design/dmf_ring.sv
// ----------------------------------------------------------------------------
// dmf_ring
// Per-channel history rings: pointer file and history RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module dmf_ring
   import dmf_pkg::*;
#(
   parameter int NUM_CHANNELS = 8,
   parameter int RING_DEPTH   = 128,
   parameter int CH_W         = 3
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              proc_en,
   input  wire  item_type   item,
   input  wire  vote_type   vote,
   output ring_status_type status,
   output logic [1:0]       hist_stage
);

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam int LX    = (PTR_W > 7 ? PTR_W : 7) + 1;
   localparam int HD    = NUM_CHANNELS * RING_DEPTH;
   localparam int HA_W  = HD > 1 ? $clog2(HD) : 1;

   logic [PTR_W-1:0] newest_ff [NUM_CHANNELS];
   logic [PTR_W-1:0] oldest_ff [NUM_CHANNELS];
   logic [PTR_W-1:0] newest_in;
   logic [PTR_W-1:0] oldest_in;
   logic [CH_W-1:0]  ci;
   logic [PTR_W-1:0] n;
   logic [PTR_W-1:0] o;
   logic [LX-1:0]    len;
   logic [LX-1:0]    len_out;
   logic [LX-1:0]    sum;
   logic [PTR_W-1:0] rd_ptr;
   logic             full;
   logic             push;
   logic             rd_en;
   logic             present;
   logic [HA_W-1:0]  wr_addr;
   logic [HA_W-1:0]  rd_addr;

   assign ci = item.ch_ok ? CH_W'(item.channel) : '0;
   assign n  = newest_ff[ci];
   assign o  = oldest_ff[ci];

   always_comb begin
      if (n >= o) begin
         len = LX'(n) - LX'(o);
      end else begin
         len = LX'(n) + LX'(RING_DEPTH) - LX'(o);
      end
      newest_in = (n == PTR_W'(RING_DEPTH - 1)) ? '0 : n + PTR_W'(1);
      full      = (newest_in == o);
      oldest_in = (o == PTR_W'(RING_DEPTH - 1)) ? '0 : o + PTR_W'(1);
      push      = proc_en && (item.func == FUNC_SAMPLE) && item.ch_ok && item.closes;
      present   = (item.func == FUNC_READ) && item.ch_ok && (LX'(item.age) < len);
      rd_en     = proc_en && present;
      if ((item.func == FUNC_SAMPLE) && item.closes && !full) begin
         len_out = len + LX'(1);
      end else begin
         len_out = len;
      end
      sum = LX'(n) + LX'(RING_DEPTH - 1) - LX'(item.age);
      if (sum >= LX'(RING_DEPTH)) begin
         sum = sum - LX'(RING_DEPTH);
      end
      rd_ptr  = PTR_W'(sum);
      wr_addr = HA_W'(ci) * HA_W'(RING_DEPTH) + HA_W'(n);
      rd_addr = HA_W'(ci) * HA_W'(RING_DEPTH) + HA_W'(rd_ptr);
   end

   assign status.present = present;
   assign status.length  = len_out[6:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            newest_ff[i] <= '0;
            oldest_ff[i] <= '0;
         end
      end else if (push) begin
         newest_ff[ci] <= newest_in;
         if (full) begin
            oldest_ff[ci] <= oldest_in;
         end
      end
   end

   dmf_ram #(
      .WIDTH (2),
      .DEPTH (HD)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (wr_addr),
      .wr_data (vote.best),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (hist_stage)
   );

endmodule

`default_nettype wire

FILE: design/decimating_mode_filter_history_top.sv
// ----------------------------------------------------------------------------
// decimating_mode_filter_history_top
// Per-channel stage mode filter with decimation into history rings.
//
//   Channel  Direction  Payload
//   req_     in         tdata: channel, stage, new_round, age; tuser: func
//   rsp_     out        tdata: picked_stage, colour, history_length;
//                       tuser: emitted, present
//   csr_     in         colour register writes, index 0..3
//
// One request per cycle while the pipeline advances. A request passes the bin
// RAM read, the compute stage with the history RAM read, and the colour lookup
// into the response register. Reset is synchronous; no clearing pass.
// A waiting response with rsp_tready low freezes the whole pipeline and holds
// req_tready low.
// ----------------------------------------------------------------------------
`default_nettype none

module decimating_mode_filter_history_top
   import dmf_pkg::*;
#(
   parameter int NUM_CHANNELS = 8,
   parameter int RING_DEPTH   = 128,
   parameter int DECIMATION   = 4
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,  // channel[2:0], stage[4:3], new_round[5], age[12:6]
   input  wire  [0:0]  req_tuser,  // func[0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [47:0] rsp_tdata,  // picked_stage[1:0], colour[33:2], history_length[40:34]
   output logic [1:0]  rsp_tuser,  // emitted[0], present[1]
   input  wire         csr_wr_en,
   input  wire  [1:0]  csr_addr,
   input  wire  [31:0] csr_wdata
);

   localparam int CH_W = NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1;
   localparam int PH_W = DECIMATION > 1 ? $clog2(DECIMATION) : 1;

   logic [31:0]     colour_ff [4];
   logic [PH_W-1:0] phase_ff;
   logic [PH_W-1:0] phase_in;

   logic            advance;
   logic            accept;
   item_type        req_item;

   logic            s1_valid_ff;
   item_type        s1_item_ff;
   vote_type        vote;
   ring_status_type status;
   logic [1:0]      hist_stage;

   logic            s2_valid_ff;
   logic            s2_read_ff;
   logic            s2_emitted_ff;
   logic            s2_present_ff;
   logic [1:0]      s2_best_ff;
   logic [6:0]      s2_len_ff;
   logic [1:0]      pick_in;

   logic            rsp_valid_ff;
   logic            rsp_emitted_ff;
   logic            rsp_present_ff;
   logic [1:0]      rsp_pick_ff;
   logic [31:0]     rsp_colour_ff;
   logic [6:0]      rsp_len_ff;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   always_comb begin
      phase_in = phase_ff;
      if ((req_tuser[0] == FUNC_SAMPLE) && req_tdata[5]) begin
         phase_in = (phase_ff == PH_W'(DECIMATION - 1)) ? '0 : phase_ff + PH_W'(1);
      end
      req_item.func    = req_tuser[0];
      req_item.channel = req_tdata[2:0];
      req_item.stage   = req_tdata[4:3];
      req_item.closes  = (phase_in == '0);
      req_item.ch_ok   = (32'(req_tdata[2:0]) < NUM_CHANNELS);
      req_item.age     = req_tdata[12:6];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         colour_ff[0] <= COLOUR0_RESET;
         colour_ff[1] <= COLOUR1_RESET;
         colour_ff[2] <= COLOUR2_RESET;
         colour_ff[3] <= COLOUR3_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            REG_COLOUR0: colour_ff[0] <= csr_wdata;
            REG_COLOUR1: colour_ff[1] <= csr_wdata;
            REG_COLOUR2: colour_ff[2] <= csr_wdata;
            REG_COLOUR3: colour_ff[3] <= csr_wdata;
            default:     colour_ff[0] <= colour_ff[0];
         endcase
      end
   end

   dmf_bins #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .CH_W         (CH_W)
   ) u_bins (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (CH_W'(req_tdata[2:0])),
      .proc_en (advance && s1_valid_ff),
      .item    (s1_item_ff),
      .vote    (vote)
   );

   dmf_ring #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .RING_DEPTH   (RING_DEPTH),
      .CH_W         (CH_W)
   ) u_ring (
      .clock      (clock),
      .reset      (reset),
      .proc_en    (advance && s1_valid_ff),
      .item       (s1_item_ff),
      .vote       (vote),
      .status     (status),
      .hist_stage (hist_stage)
   );

   always_comb begin
      if (s2_read_ff) begin
         pick_in = s2_present_ff ? hist_stage : 2'd0;
      end else begin
         pick_in = s2_emitted_ff ? s2_best_ff : 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         phase_ff     <= accept ? phase_in : phase_ff;
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         s1_item_ff     <= req_item;
         s2_read_ff     <= (s1_item_ff.func == FUNC_READ);
         s2_emitted_ff  <= (s1_item_ff.func == FUNC_SAMPLE) && s1_item_ff.ch_ok
                           && s1_item_ff.closes;
         s2_present_ff  <= status.present;
         s2_best_ff     <= vote.best;
         s2_len_ff      <= s1_item_ff.ch_ok ? status.length : 7'd0;
         rsp_emitted_ff <= s2_emitted_ff;
         rsp_present_ff <= s2_read_ff && s2_present_ff;
         rsp_pick_ff    <= pick_in;
         rsp_colour_ff  <= colour_ff[pick_in];
         rsp_len_ff     <= s2_len_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_len_ff, rsp_colour_ff, rsp_pick_ff};
   assign rsp_tuser  = {rsp_present_ff, rsp_emitted_ff};

endmodule

`default_nettype wire
